// File: hdl/pfx_pkg.sv
// ============================================================================
// pfx_pkg
// Shared types, codes and helpers for the postfix expression evaluator.
// ============================================================================
`default_nettype none

package pfx_pkg;

    localparam int STACK_DEPTH_DEF = 20;
    localparam int DATA_W          = 32;   // Q16.16 word
    localparam int FRAC_W          = 16;
    localparam int OP_W            = 3;
    localparam int OPND_W          = 15;
    localparam int STATUS_W        = 2;
    localparam int WIDE_W          = 48;   // headroom for sums and scaled products

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_END  = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_DIVZERO   = 2'd3
    } t_status;

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // clamp a wide signed value to the Q16.16 range
    function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(Q_MAX);
        lo = WIDE_W'(Q_MIN);
        if (v > hi) begin
            sat_q = Q_MAX;
        end else if (v < lo) begin
            sat_q = Q_MIN;
        end else begin
            sat_q = v[DATA_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: hdl/pfx_ram.sv
// ============================================================================
// pfx_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module pfx_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 20,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/pfx_div.sv
// ============================================================================
// pfx_div
// Iterative signed Q16.16 divider, one quotient bit per cycle, saturating.
// ============================================================================
`default_nettype none

module pfx_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [pfx_pkg::DATA_W-1:0]  i_dividend,
    input  wire logic signed [pfx_pkg::DATA_W-1:0]  i_divisor,   // nonzero
    output logic                                    o_done,
    output logic signed [pfx_pkg::DATA_W-1:0]       o_quot
);
    import pfx_pkg::*;

    localparam int CW = $clog2(DATA_W);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_INIT = 4'b0010,
        D_LOOP = 4'b0100,
        D_FIN  = 4'b1000
    } t_dstate;

    t_dstate           r_state, n_state;
    logic [DATA_W-1:0] r_a_mag, n_a_mag;
    logic [DATA_W-1:0] r_b_mag, n_b_mag;
    logic              r_neg, n_neg;
    logic              r_ovf, n_ovf;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_dvd, n_dvd;     // dividend bits in, quotient bits out
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_done, n_done;
    logic signed [DATA_W-1:0] r_quot, n_quot;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;

    assign shifted = {r_rem, r_dvd[DATA_W-1]};
    assign diff    = shifted - {1'b0, r_b_mag};
    assign fits    = (shifted >= {1'b0, r_b_mag});

    always_comb begin
        n_state = r_state;
        n_a_mag = r_a_mag;
        n_b_mag = r_b_mag;
        n_neg   = r_neg;
        n_ovf   = r_ovf;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_quot  = r_quot;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_a_mag = i_dividend[DATA_W-1] ? DATA_W'(-i_dividend) : i_dividend;
                    n_b_mag = i_divisor[DATA_W-1]  ? DATA_W'(-i_divisor)  : i_divisor;
                    n_neg   = i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
                    n_state = D_INIT;
                end
            end
            D_INIT: begin
                // quotient reaches 2^32 exactly when the integer part >= divisor
                n_ovf   = ({{FRAC_W{1'b0}}, r_a_mag[DATA_W-1:FRAC_W]} >= r_b_mag);
                n_rem   = {{FRAC_W{1'b0}}, r_a_mag[DATA_W-1:FRAC_W]};
                n_dvd   = {r_a_mag[FRAC_W-1:0], {FRAC_W{1'b0}}};
                n_cnt   = '0;
                n_state = n_ovf ? D_FIN : D_LOOP;
            end
            D_LOOP: begin
                n_rem = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
                n_dvd = {r_dvd[DATA_W-2:0], fits};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(DATA_W - 1)) begin
                    n_state = D_FIN;
                end
            end
            D_FIN: begin
                if (r_neg) begin
                    n_quot = (r_ovf || (r_dvd > Q_MIN)) ? Q_MIN : DATA_W'(-r_dvd);
                end else begin
                    n_quot = (r_ovf || r_dvd[DATA_W-1]) ? Q_MAX : r_dvd;
                end
                n_done  = 1'b1;
                n_state = D_IDLE;
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_a_mag <= n_a_mag;
        r_b_mag <= n_b_mag;
        r_neg   <= n_neg;
        r_ovf   <= n_ovf;
        r_rem   <= n_rem;
        r_dvd   <= n_dvd;
        r_cnt   <= n_cnt;
        r_quot  <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// File: hdl/postfix_expression_evaluator.sv
// ============================================================================
// postfix_expression_evaluator
// RPN evaluator over a Q16.16 operand stack held in a synchronous RAM.
// ============================================================================
// Sequence: push, end, odd codes, overflow and underflow finish as the token
//   is accepted; add/sub and divide by zero finish in S_EXEC after the RAM
//   read, multiply in S_MULF, divide in S_DIVW, one quotient bit per cycle.
// Throughput: one token in flight; the next is taken in S_IDLE once the result
//   slot is free or draining. Divide sets the worst-case token rate.
// Reset: synchronous, active low; empties the stack, no RAM clearing pass.
// ============================================================================
`default_nettype none

module postfix_expression_evaluator #(
    parameter  int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF,
    localparam int LW          = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // token channel
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [pfx_pkg::OP_W-1:0]            i_op,
    input  wire logic [pfx_pkg::OPND_W-1:0]          i_operand,
    // result channel
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [pfx_pkg::DATA_W-1:0]        o_value,
    output logic                                     o_done_res,
    output logic [pfx_pkg::STATUS_W-1:0]             o_status,
    output logic [LW-1:0]                            o_level
);
    import pfx_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);

    // Sequencer: idle takes a token; exec has the first operand from RAM.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_MULF = 4'b0100,
        S_DIVW = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [OP_W-1:0]          r_op, n_op;
    logic [LW-1:0]            r_level, n_level;
    // copy of the top entry (zero when empty) so only one RAM read is needed
    logic signed [DATA_W-1:0] r_top, n_top;
    logic signed [2*DATA_W-1:0] r_prod, n_prod;

    // result register
    logic                     r_o_valid;
    logic signed [DATA_W-1:0] r_o_value;
    logic                     r_o_done;
    logic [STATUS_W-1:0]      r_o_status;
    logic [LW-1:0]            r_o_level;

    // completion of the current token
    logic                     fin;
    logic signed [DATA_W-1:0] fin_value;
    logic                     fin_done;
    logic [STATUS_W-1:0]      fin_status;

    // stack RAM
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [DATA_W-1:0]        rd_data;

    logic                     div_start;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_quot;

    logic                     accept;
    logic signed [DATA_W-1:0] first;
    logic signed [DATA_W-1:0] pushed;
    logic signed [DATA_W:0]   sum;
    logic signed [2*DATA_W-1:0] prod_adj;
    logic [AW-1:0]            below_addr;

    // A token is only taken when the result slot is free (or draining now),
    // so every completion below finds room in the result register.
    assign o_stall = (r_state != S_IDLE) || (r_o_valid && i_stall);
    assign accept  = i_valid && !o_stall;

    assign first      = rd_data;
    assign pushed     = {1'b0, i_operand, {FRAC_W{1'b0}}};
    assign below_addr = AW'(r_level - LW'(2));
    assign rd_addr    = below_addr;

    // add/sub: exact 33-bit result, clamped on completion
    assign sum = (r_op == OP_SUB)
               ? ($signed({first[DATA_W-1], first}) - $signed({r_top[DATA_W-1], r_top}))
               : ($signed({first[DATA_W-1], first}) + $signed({r_top[DATA_W-1], r_top}));

    // product / 2^16, truncated toward zero: bias negatives before the shift
    assign prod_adj = r_prod + (r_prod[2*DATA_W-1] ? (2*DATA_W)'(2**FRAC_W - 1)
                                                    : (2*DATA_W)'(0));

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_level    = r_level;
        n_top      = r_top;
        n_prod     = r_prod;
        fin        = 1'b0;
        fin_value  = r_top;
        fin_done   = 1'b0;
        fin_status = ST_OK;
        wr_en      = 1'b0;
        wr_addr    = below_addr;
        wr_data    = r_top;
        rd_en      = 1'b0;
        div_start  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_op) inside
                        OP_PUSH: begin
                            fin = 1'b1;
                            if (r_level >= LW'(STACK_DEPTH)) begin
                                fin_status = ST_OVERFLOW;
                            end else begin
                                wr_en     = 1'b1;
                                wr_addr   = AW'(r_level);
                                wr_data   = pushed;
                                n_top     = pushed;
                                n_level   = r_level + LW'(1);
                                fin_value = pushed;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                            if (r_level < LW'(2)) begin
                                fin        = 1'b1;
                                fin_status = ST_UNDERFLOW;
                            end else begin
                                rd_en   = 1'b1;
                                n_op    = i_op;
                                n_state = S_EXEC;
                            end
                        end
                        OP_END: begin
                            fin        = 1'b1;
                            fin_done   = 1'b1;
                            fin_status = (r_level == '0) ? ST_UNDERFLOW : ST_OK;
                            n_level    = '0;
                            n_top      = '0;
                        end
                        default: begin
                            // unused codes: report the top, stack untouched
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_ADD, OP_SUB: begin
                        fin       = 1'b1;
                        fin_value = sat_q(WIDE_W'(sum));
                        wr_en     = 1'b1;
                        wr_data   = fin_value;
                        n_top     = fin_value;
                        n_level   = r_level - LW'(1);
                        n_state   = S_IDLE;
                    end
                    OP_MUL: begin
                        n_prod  = first * r_top;
                        n_state = S_MULF;
                    end
                    default: begin
                        // divide; a zero divisor leaves both operands in place
                        if (r_top == '0) begin
                            fin        = 1'b1;
                            fin_status = ST_DIVZERO;
                            n_state    = S_IDLE;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIVW;
                        end
                    end
                endcase
            end
            S_MULF: begin
                fin       = 1'b1;
                fin_value = sat_q(prod_adj[2*DATA_W-1:FRAC_W]);
                wr_en     = 1'b1;
                wr_data   = fin_value;
                n_top     = fin_value;
                n_level   = r_level - LW'(1);
                n_state   = S_IDLE;
            end
            S_DIVW: begin
                if (div_done) begin
                    fin       = 1'b1;
                    fin_value = div_quot;
                    wr_en     = 1'b1;
                    wr_data   = div_quot;
                    n_top     = div_quot;
                    n_level   = r_level - LW'(1);
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_level   <= '0;
            r_top     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
            r_top   <= n_top;
            if (fin) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
        r_op   <= n_op;
        r_prod <= n_prod;
        if (fin) begin
            r_o_value  <= fin_value;
            r_o_done   <= fin_done;
            r_o_status <= fin_status;
            r_o_level  <= n_level;
        end
    end

    pfx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    pfx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (first),
        .i_divisor  (r_top),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_valid    = r_o_valid;
    assign o_value    = r_o_value;
    assign o_done_res = r_o_done;
    assign o_status   = r_o_status;
    assign o_level    = r_o_level;

endmodule

`default_nettype wire

// File: tb/sv/postfix_expression_evaluator_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// postfix_expression_evaluator_tb
// Self-checking bench for the RPN evaluator. Tokens go in over a valid/stall
// channel. A shadow operand stack in the bench works out every result, and a
// checker on the result channel compares each transfer field by field.
// Directed tokens cover the special cases and saturation. A held-off receiver
// fills the block and overflows the stack. Random postfix expressions then
// run with and without random idling on both channels.
// ============================================================================
`default_nettype none

module postfix_expression_evaluator_tb;

    import pfx_pkg::*;

    localparam int DEPTH      = STACK_DEPTH_DEF;
    localparam int LVL_W      = $clog2(DEPTH + 1);
    localparam int IDLE_PCT   = 19;
    localparam int MAX_REPORT = 10;
    localparam int DRAIN_MAX  = 20000;     // cycles allowed for the result queue to empty
    localparam int TAIL_CYC   = 60;        // tail wait, long enough for a divide to finish

    // op codes the block must ignore
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     done_res;
        t_status                  status;
        logic [LVL_W-1:0]         level;
    } t_rpn_result;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic                     i_clk     = 1'b0;
    logic                     i_rst_n   = 1'b0;
    logic                     i_valid   = 1'b0;
    logic                     o_stall;
    logic [OP_W-1:0]          i_op      = OP_PUSH;
    logic [OPND_W-1:0]        i_operand = '0;
    logic                     o_valid;
    logic                     i_stall   = 1'b0;
    logic signed [DATA_W-1:0] o_value;
    logic                     o_done_res;
    logic [STATUS_W-1:0]      o_status;
    logic [LVL_W-1:0]         o_level;

    postfix_expression_evaluator #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_op       (i_op),
        .i_operand  (i_operand),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_value    (o_value),
        .o_done_res (o_done_res),
        .o_status   (o_status),
        .o_level    (o_level)
    );

    // 2 ns period
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic signed [DATA_W-1:0] shadow_stack [DEPTH];
    int                       shadow_level = 0;
    t_rpn_result              token_results [$];   // results owed by the block, oldest first

    bit  no_idle       = 1'b0;   // set for the back-to-back stretch
    int  hold_off_req  = 0;      // receiver hold-off, picked up by the receiver process
    int  hold_left     = 0;
    int  tokens_sent   = 0;
    int  expressions   = 0;
    int  results_seen  = 0;
    int  mismatches    = 0;
    int  status_seen [4];

    // ------------------------------------------------------------------------
    // Shadow evaluator
    // ------------------------------------------------------------------------
    function automatic logic signed [DATA_W-1:0] clamp_q16(input longint w);
        if (w > Q_HI) return Q_HI[DATA_W-1:0];
        if (w < Q_LO) return Q_LO[DATA_W-1:0];
        return w[DATA_W-1:0];
    endfunction

    // apply one accepted token to the shadow stack and queue the result it owes
    task automatic eval_token(input logic [OP_W-1:0] op, input logic [OPND_W-1:0] opnd);
        t_rpn_result r;
        longint      lhs;
        longint      rhs;
        longint      w;
        r.status   = ST_OK;
        r.done_res = 1'b0;
        w          = 0;
        case (op)
            OP_PUSH: begin
                if (shadow_level >= DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    shadow_stack[shadow_level] = {1'b0, opnd, {FRAC_W{1'b0}}};
                    shadow_level++;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (shadow_level < 2) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    // top of stack is the right-hand operand
                    rhs = shadow_stack[shadow_level-1];
                    lhs = shadow_stack[shadow_level-2];
                    case (op)
                        OP_ADD: w = lhs + rhs;
                        OP_SUB: w = lhs - rhs;
                        OP_MUL: w = (lhs * rhs) / 65536;
                        default: begin
                            if (rhs == 0) r.status = ST_DIVZERO;
                            else          w = (lhs * 65536) / rhs;
                        end
                    endcase
                    if (r.status == ST_OK) begin
                        shadow_level--;
                        shadow_stack[shadow_level-1] = clamp_q16(w);
                    end
                end
            end
            OP_END: begin
                r.done_res = 1'b1;
                if (shadow_level == 0) r.status = ST_UNDERFLOW;
            end
            default: ;   // reserved codes leave everything alone
        endcase
        // report the top; on end this is taken before the stack is cleared
        r.value = (shadow_level == 0) ? '0 : shadow_stack[shadow_level-1];
        if (op == OP_END) shadow_level = 0;
        r.level = shadow_level[LVL_W-1:0];
        token_results.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Token sender: drives at the falling edge, transfer seen at the rising edge
    // ------------------------------------------------------------------------
    task automatic send_token(input logic [OP_W-1:0] op, input logic [OPND_W-1:0] opnd);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_op      <= op;
        i_operand <= opnd;
        // payload holds until the block takes it
        do @(posedge i_clk); while (o_stall);
        eval_token(op, opnd);
        tokens_sent++;
    endtask

    // operand mix: edges, small integers, bytes and full range
    function automatic logic [OPND_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return OPND_W'($urandom_range(0, 9));
            6, 7:       return OPND_W'($urandom_range(0, 255));
            default:    return OPND_W'($urandom);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_arith();
        case ($urandom_range(0, 3))
            0:       return OP_ADD;
            1:       return OP_SUB;
            2:       return OP_MUL;
            default: return OP_DIV;
        endcase
    endfunction

    // one well-formed expression, or now and then a run of raw tokens
    task automatic send_expression();
        int  pushes_left;
        int  depth;
        bit  push_all_first;
        int  n;
        expressions++;
        if ($urandom_range(0, 99) < 15) begin
            // noise: any code, any operand, stack may under- or overflow
            n = $urandom_range(1, 6);
            repeat (n) send_token(OP_W'($urandom_range(0, 7)), OPND_W'($urandom));
            return;
        end
        // mostly short, sometimes deep enough to hit or pass the stack limit
        pushes_left    = ($urandom_range(0, 9) == 0) ? $urandom_range(15, DEPTH + 3)
                                                     : $urandom_range(1, 8);
        push_all_first = ($urandom_range(0, 3) == 0);
        depth          = 0;
        while (pushes_left > 0 || depth > 1) begin
            if (pushes_left > 0 && (depth < 2 || push_all_first || $urandom_range(0, 1))) begin
                send_token(OP_PUSH, pick_operand());
                pushes_left--;
                depth++;
            end else begin
                send_token(pick_arith(), OPND_W'($urandom));
                depth--;
            end
        end
        send_token(OP_END, OPND_W'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall, long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_off_req > 0) begin
            hold_left    = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (no_idle) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORT) $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        t_rpn_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            status_seen[o_status]++;
            if (token_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result value=%0d done=%0b status=%0d level=%0d",
                                        o_value, o_done_res, o_status, o_level));
            end else begin
                exp_r = token_results.pop_front();
                if (o_value !== exp_r.value || o_done_res !== exp_r.done_res ||
                    o_status !== exp_r.status || o_level !== exp_r.level) begin
                    note_mismatch($sformatf(
                        "exp value=%0d done=%0b status=%0d level=%0d, got %0d %0b %0d %0d",
                        exp_r.value, exp_r.done_res, exp_r.status, exp_r.level,
                        o_value, o_done_res, o_status, o_level));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // empty-stack end and arithmetic, one-entry arithmetic, saturation both
    // ways, divide by zero, reserved codes, tiny quotients and a fraction
    task automatic test_special_cases();
        expressions++;
        send_token(OP_END,    '0);    // end on an empty stack
        send_token(OP_ADD,    '0);    // nothing to pop
        send_token(OP_PUSH,   '1);
        send_token(OP_SUB,    '1);    // only one entry
        send_token(OP_PUSH,   '1);
        send_token(OP_ADD,    '0);    // saturates high
        send_token(OP_PUSH,   '0);
        send_token(OP_DIV,    '0);    // divide by zero, both entries stay
        send_token(OP_RSVD_6, '0);
        send_token(OP_RSVD_7, '1);
        send_token(OP_MUL,    '0);    // max times zero
        send_token(OP_PUSH,   '1);
        send_token(OP_SUB,    '0);    // goes negative
        send_token(OP_PUSH,   '1);
        send_token(OP_MUL,    '0);    // saturates low
        send_token(OP_PUSH,   15'd1);
        send_token(OP_PUSH,   '1);
        send_token(OP_DIV,    '0);    // tiny quotient
        send_token(OP_DIV,    '0);    // huge negative over tiny, saturates low
        send_token(OP_PUSH,   15'd5);
        send_token(OP_PUSH,   15'd2);
        send_token(OP_DIV,    '0);    // 2.5, fractional result
        send_token(OP_END,    '0);
    endtask

    // receiver holds off while the sender overfills the stack
    task automatic test_stall_and_overflow();
        expressions++;
        hold_off_req = 300;
        repeat (DEPTH + 2) send_token(OP_PUSH, pick_operand());
        send_token(OP_ADD, '0);
        send_token(OP_END, '0);
    endtask

    task automatic test_random_expressions(input int n_tokens);
        int stop_at;
        stop_at = tokens_sent + n_tokens;
        while (tokens_sent < stop_at) send_expression();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int waited;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_special_cases();
        test_stall_and_overflow();
        no_idle = 1'b1;
        test_random_expressions(400);
        no_idle = 1'b0;
        test_random_expressions(1400);

        @(negedge i_clk);
        i_valid <= 1'b0;

        waited = 0;
        while (token_results.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYC) @(posedge i_clk);
        while (token_results.size() != 0) begin
            void'(token_results.pop_front());
            note_mismatch("result never arrived");
        end

        $display("covered %0d tokens in %0d expressions, %0d results checked",
                 tokens_sent, expressions, results_seen);
        $display("status mix: ok %0d, overflow %0d, underflow %0d, divide by zero %0d",
                 status_seen[ST_OK], status_seen[ST_OVERFLOW],
                 status_seen[ST_UNDERFLOW], status_seen[ST_DIVZERO]);
        if (mismatches == 0) begin
            $display("postfix_expression_evaluator_tb: done, clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("postfix_expression_evaluator_tb: done, errors");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", token_results.size());
        $display("postfix_expression_evaluator_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hdl/pfx_pkg.sv
hdl/pfx_ram.sv
hdl/pfx_div.sv
hdl/postfix_expression_evaluator.sv
tb/sv/postfix_expression_evaluator_tb.sv
